/* hw/rtl/quadratic_root_solver_assert.svh */
// Assertion macros for the quadratic root solver.
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`ifndef SYNTH
`define QRS_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  prop) else $error("qrs assertion failed");
`define QRS_ASSERT_RST(lbl, prop) lbl: assert property (@(posedge clk) prop) \
  else $error("qrs reset assertion failed");
`else
`define QRS_ASSERT(lbl, prop)
`define QRS_ASSERT_RST(lbl, prop)
`endif
`endif

/* hw/rtl/qrs_pkg.sv */
// Types and constants shared by the quadratic root solver files.
`timescale 1ns / 1ps
`default_nettype none
package qrs_pkg;
  localparam int COEF_W      = 16;
  localparam int VAL_W       = 32;
  localparam int MAG_W       = 33;
  localparam int RAD_W       = 64;
  localparam int ROOT_W      = 32;
  localparam int NUM_W       = 34;
  localparam int DEN_W       = 16;
  localparam int SQRT_STAGES = 32;
  localparam int DIV_STAGES  = 34;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_DISTINCT = 2'd1,
    KIND_EQUAL    = 2'd2,
    KIND_COMPLEX  = 2'd3
  } kind_t;
endpackage
`default_nettype wire

/* hw/rtl/qrs_if.sv */
// Valid/ready channel interfaces for coefficient and root transactions.
`timescale 1ns / 1ps
`default_nettype none
interface qrs_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [qrs_pkg::COEF_W-1:0]  coef_a;
  logic signed [qrs_pkg::COEF_W-1:0]  coef_b;
  logic signed [qrs_pkg::COEF_W-1:0]  coef_c;
  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_out_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         root_kind;
  logic signed [qrs_pkg::VAL_W-1:0]   first_value;
  logic signed [qrs_pkg::VAL_W-1:0]   second_value;
  modport source (output valid, root_kind, first_value, second_value, input ready);
  modport sink (input valid, root_kind, first_value, second_value, output ready);
endinterface
`default_nettype wire

/* hw/rtl/quadratic_root_solver.sv */
// Quadratic root solver top level: discriminant, square root, division, saturation.
//
// Usage: coefficient transactions (a, b, c in signed Q8.8) arrive on in_ch, a
// valid/ready channel; one root transaction per coefficient set leaves on
// out_ch in the same order. root_kind tells not quadratic, real distinct, real
// equal or complex; first_value and second_value are signed Q16.16, truncated
// toward zero and saturated.
// Pipeline: a products register and a discriminant register, 32 square-root
// stages (one root bit each), one numerator stage, 34 divider stages (one
// quotient bit each), one output stage, from acceptance to out_ch.valid.
// Throughput: one transaction per cycle while out_ch.ready stays high.
// Stall: when the output register holds a result and out_ch.ready is low, the
// whole pipeline holds and in_ch.ready drops; nothing is lost or repeated.
// Reset: rst_n (synchronous, active low) clears all valid bits; the pipeline
// comes up empty and in_ch.ready is high.
`timescale 1ns / 1ps
`default_nettype none
`include "quadratic_root_solver_assert.svh"
module quadratic_root_solver (
  input  wire logic clk,
  input  wire logic rst_n,
  qrs_in_if.sink    in_ch,
  qrs_out_if.source out_ch
);
  import qrs_pkg::*;

  localparam int SQ_TAG_W = 2 + COEF_W + VAL_W;
  localparam int D1_TAG_W = 3;
  localparam int D2_TAG_W = 1;
  localparam int DISC_W   = 35;

  logic en;

  logic                     v1_r;
  logic signed [COEF_W-1:0] a1_r, b1_r;
  logic signed [31:0]       bb1_r, ac1_r;

  logic                     v2_r;
  kind_t                    kind2_r;
  logic [MAG_W-1:0]         mag2_r;
  logic signed [VAL_W-1:0]  p2_r;
  logic signed [COEF_W-1:0] a2_r;
  logic signed [DISC_W-1:0] disc_nxt;
  kind_t                    kind_nxt;

  logic                     sq_valid;
  logic [ROOT_W-1:0]        sq_root;
  logic [SQ_TAG_W-1:0]      sq_tag;
  kind_t                    sq_kind;
  logic signed [COEF_W-1:0] sq_a;
  logic signed [VAL_W-1:0]  sq_p;
  logic signed [NUM_W-1:0]  s_ext, p_ext, n1, n2;

  logic                     v3_r;
  kind_t                    kind3_r;
  logic [NUM_W-1:0]         mag1_r, mag2n_r;
  logic                     neg1_r, neg2_r;
  logic [DEN_W-1:0]         den3_r;

  logic                     d1_valid, d2_valid;
  logic [NUM_W-1:0]         q1, q2;
  logic [D1_TAG_W-1:0]      d1_tag;
  logic [D2_TAG_W-1:0]      d2_tag;

  logic                     out_valid_r;
  kind_t                    out_kind_r;
  logic signed [VAL_W-1:0]  out_first_r, out_second_r;

  function automatic logic signed [VAL_W-1:0] sat_val(input logic [NUM_W-1:0] q,
                                                      input logic neg);
    logic [NUM_W-1:0] lim;
    logic [VAL_W-1:0] res;
    lim = {{(NUM_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
    if (neg) begin
      if (q > lim) res = {1'b1, {(VAL_W-1){1'b0}}};
      else         res = -q[VAL_W-1:0];
    end else begin
      if (q > lim) res = {1'b0, {(VAL_W-1){1'b1}}};
      else         res = q[VAL_W-1:0];
    end
    return signed'(res);
  endfunction

  assign en          = out_ch.ready || !out_valid_r;
  assign in_ch.ready = en;

  // products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
    end
    if (en) begin
      a1_r  <= in_ch.coef_a;
      b1_r  <= in_ch.coef_b;
      bb1_r <= in_ch.coef_b * in_ch.coef_b;
      ac1_r <= in_ch.coef_a * in_ch.coef_c;
    end
  end

  // discriminant and classification
  always_comb begin
    disc_nxt = DISC_W'(bb1_r) - (DISC_W'(ac1_r) <<< 2);
    if (a1_r == '0)                 kind_nxt = KIND_NONE;
    else if (disc_nxt > 0)          kind_nxt = KIND_DISTINCT;
    else if (disc_nxt == '0)        kind_nxt = KIND_EQUAL;
    else                            kind_nxt = KIND_COMPLEX;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      kind2_r <= kind_nxt;
      mag2_r  <= disc_nxt[DISC_W-1] ? MAG_W'(-disc_nxt) : MAG_W'(disc_nxt);
      p2_r    <= -(VAL_W'(b1_r) <<< 15);
      a2_r    <= a1_r;
    end
  end

  qrs_sqrt #(.TAG_W(SQ_TAG_W)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v2_r),
    .in_rad    ({1'b0, mag2_r, 30'b0}),
    .in_tag    ({kind2_r, a2_r, p2_r}),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_tag   (sq_tag)
  );

  // numerator selection
  always_comb begin
    sq_kind = kind_t'(sq_tag[SQ_TAG_W-1 -: 2]);
    sq_a    = sq_tag[VAL_W +: COEF_W];
    sq_p    = sq_tag[VAL_W-1:0];
    s_ext   = {2'b00, sq_root};
    p_ext   = NUM_W'(sq_p);
    case (sq_kind)
      KIND_DISTINCT: begin
        n1 = p_ext + s_ext;
        n2 = p_ext - s_ext;
      end
      KIND_EQUAL: begin
        n1 = p_ext;
        n2 = p_ext;
      end
      KIND_COMPLEX: begin
        n1 = p_ext;
        n2 = s_ext;
      end
      default: begin
        n1 = '0;
        n2 = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= sq_valid;
    end
    if (en) begin
      kind3_r <= sq_kind;
      mag1_r  <= n1[NUM_W-1] ? -n1 : n1;
      mag2n_r <= n2[NUM_W-1] ? -n2 : n2;
      neg1_r  <= n1[NUM_W-1] ^ sq_a[COEF_W-1];
      neg2_r  <= n2[NUM_W-1] ^ sq_a[COEF_W-1];
      den3_r  <= sq_a[COEF_W-1] ? DEN_W'(-sq_a) : DEN_W'(sq_a);
    end
  end

  qrs_div #(.TAG_W(D1_TAG_W)) u_div_first (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v3_r),
    .in_num    (mag1_r),
    .in_den    (den3_r),
    .in_tag    ({kind3_r, neg1_r}),
    .out_valid (d1_valid),
    .out_quo   (q1),
    .out_tag   (d1_tag)
  );

  qrs_div #(.TAG_W(D2_TAG_W)) u_div_second (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v3_r),
    .in_num    (mag2n_r),
    .in_den    (den3_r),
    .in_tag    (neg2_r),
    .out_valid (d2_valid),
    .out_quo   (q2),
    .out_tag   (d2_tag)
  );

  // output register with saturation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d1_valid;
    end
    if (en) begin
      out_kind_r <= kind_t'(d1_tag[2:1]);
      if (kind_t'(d1_tag[2:1]) == KIND_NONE) begin
        out_first_r  <= '0;
        out_second_r <= '0;
      end else begin
        out_first_r  <= sat_val(q1, d1_tag[0]);
        out_second_r <= sat_val(q2, d2_tag[0]);
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.root_kind    = out_kind_r;
  assign out_ch.first_value  = out_first_r;
  assign out_ch.second_value = out_second_r;

  `QRS_ASSERT(a_div_lanes_aligned, d1_valid == d2_valid)
  `QRS_ASSERT(a_none_is_zero, (out_valid_r && out_kind_r == KIND_NONE) |-> (out_first_r == '0 && out_second_r == '0))
  `QRS_ASSERT(a_equal_roots_match, (out_valid_r && out_kind_r == KIND_EQUAL) |-> (out_first_r == out_second_r))
  `QRS_ASSERT_RST(a_empty_after_reset, $past(!rst_n) |-> !out_valid_r)
endmodule
`default_nettype wire

/* hw/rtl/qrs_sqrt.sv */
// Pipelined integer square root, one root bit per stage, with a side tag.
`timescale 1ns / 1ps
`default_nettype none
module qrs_sqrt #(
  parameter int TAG_W = 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic [qrs_pkg::RAD_W-1:0]     in_rad,
  input  wire logic [TAG_W-1:0]              in_tag,
  output logic                               out_valid,
  output logic [qrs_pkg::ROOT_W-1:0]         out_root,
  output logic [TAG_W-1:0]                   out_tag
);
  import qrs_pkg::*;

  localparam int REM_W = ROOT_W + 4;

  logic             valid_r [SQRT_STAGES];
  logic [REM_W-1:0] rem_r   [SQRT_STAGES];
  logic [ROOT_W-1:0] root_r [SQRT_STAGES];
  logic [RAD_W-1:0] rad_r   [SQRT_STAGES];
  logic [TAG_W-1:0] tag_r   [SQRT_STAGES];

  for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
    logic             v_in;
    logic [REM_W-1:0] rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0] rad_in;
    logic [TAG_W-1:0] tag_in;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;
    logic [REM_W-1:0] rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    if (i == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = in_rad;
      assign tag_in  = in_tag;
    end else begin : g_next
      assign v_in    = valid_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign rad_in  = rad_r[i-1];
      assign tag_in  = tag_r[i-1];
    end

    always_comb begin
      rem_sh   = {rem_in[REM_W-3:0], rad_in[RAD_W-1:RAD_W-2]};
      trial    = {2'b00, root_in, 2'b01};
      ge       = (rem_sh >= trial);
      rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
      root_nxt = {root_in[ROOT_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
      end else if (en) begin
        valid_r[i] <= v_in;
      end
      if (en) begin
        rem_r[i]  <= rem_nxt;
        root_r[i] <= root_nxt;
        rad_r[i]  <= {rad_in[RAD_W-3:0], 2'b00};
        tag_r[i]  <= tag_in;
      end
    end
  end

  assign out_valid = valid_r[SQRT_STAGES-1];
  assign out_root  = root_r[SQRT_STAGES-1];
  assign out_tag   = tag_r[SQRT_STAGES-1];
endmodule
`default_nettype wire

/* hw/rtl/qrs_div.sv */
// Pipelined unsigned restoring divider, one quotient bit per stage, with a side tag.
`timescale 1ns / 1ps
`default_nettype none
module qrs_div #(
  parameter int TAG_W = 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic [qrs_pkg::NUM_W-1:0]     in_num,
  input  wire logic [qrs_pkg::DEN_W-1:0]     in_den,
  input  wire logic [TAG_W-1:0]              in_tag,
  output logic                               out_valid,
  output logic [qrs_pkg::NUM_W-1:0]          out_quo,
  output logic [TAG_W-1:0]                   out_tag
);
  import qrs_pkg::*;

  localparam int REM_W = DEN_W + 1;

  logic             valid_r [DIV_STAGES];
  logic [REM_W-1:0] rem_r   [DIV_STAGES];
  logic [NUM_W-1:0] quo_r   [DIV_STAGES];
  logic [NUM_W-1:0] num_r   [DIV_STAGES];
  logic [DEN_W-1:0] den_r   [DIV_STAGES];
  logic [TAG_W-1:0] tag_r   [DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    logic             v_in;
    logic [REM_W-1:0] rem_in;
    logic [NUM_W-1:0] quo_in;
    logic [NUM_W-1:0] num_in;
    logic [DEN_W-1:0] den_in;
    logic [TAG_W-1:0] tag_in;
    logic [REM_W-1:0] rem_sh;
    logic             ge;

    if (i == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = '0;
      assign quo_in = '0;
      assign num_in = in_num;
      assign den_in = in_den;
      assign tag_in = in_tag;
    end else begin : g_next
      assign v_in   = valid_r[i-1];
      assign rem_in = rem_r[i-1];
      assign quo_in = quo_r[i-1];
      assign num_in = num_r[i-1];
      assign den_in = den_r[i-1];
      assign tag_in = tag_r[i-1];
    end

    always_comb begin
      rem_sh = {rem_in[REM_W-2:0], num_in[NUM_W-1]};
      ge     = (rem_sh >= {1'b0, den_in});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
      end else if (en) begin
        valid_r[i] <= v_in;
      end
      if (en) begin
        rem_r[i] <= ge ? (rem_sh - {1'b0, den_in}) : rem_sh;
        quo_r[i] <= {quo_in[NUM_W-2:0], ge};
        num_r[i] <= {num_in[NUM_W-2:0], 1'b0};
        den_r[i] <= den_in;
        tag_r[i] <= tag_in;
      end
    end
  end

  assign out_valid = valid_r[DIV_STAGES-1];
  assign out_quo   = quo_r[DIV_STAGES-1];
  assign out_tag   = tag_r[DIV_STAGES-1];
endmodule
`default_nettype wire
